### design/ple_pkg.sv
// Shared constants, types and operation codes of the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int OP_W     = 3;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [OP_W-1:0] OP_SHOW   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET    = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd4;

    typedef logic [OP_W-1:0]          t_op;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_count;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic              we;
        t_addr             waddr;
        logic [DATA_W-1:0] wdata;
        t_addr             raddr;
    } t_ram_req;

endpackage

### design/ple_if.sv
// Request and response channel interfaces of the positional list engine.
`timescale 1ns / 1ps
interface ple_req_if;
    import ple_pkg::*;

    logic  valid;
    logic  ready;
    t_op   operation;
    t_pos  position;
    t_word item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink (input valid, input operation, input position, input item_value,
                  output ready);
endinterface

interface ple_rsp_if;
    import ple_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_word   read_value;
    logic    last;

    modport source (output valid, output status, output read_value, output last,
                    input ready);
    modport sink (input valid, input status, input read_value, input last,
                  output ready);
endinterface

### design/ple_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/ple_seq.sv
// Sequencer that decodes requests, moves entries through the RAM and drives results.
`timescale 1ns / 1ps
module ple_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ple_req_if.sink                i_req,
    ple_rsp_if.source              o_rsp,
    output ple_pkg::t_ram_req      o_ram,
    input  logic [ple_pkg::DATA_W-1:0] i_rdata
);
    import ple_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GET  = 7'b0000010,
        S_SHOW = 7'b0000100,
        S_UP   = 7'b0001000,
        S_PUTV = 7'b0010000,
        S_DN   = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    t_count  r_count, n_count;
    t_addr   r_idx, n_idx;
    t_addr   r_slot, n_slot;
    t_word   r_val, n_val;
    t_status r_status, n_status;
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    t_word   r_out_value, n_out_value;
    logic    r_out_last, n_out_last;

    logic    out_free;
    logic    accept;
    logic    fin;
    t_status fin_status;
    logic    get_ok;
    logic    ins_ok;
    logic    not_full;
    logic    at_end;
    t_addr   pos_slot;
    t_addr   ins_slot;
    t_word   rd_word;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign accept   = i_req.valid && (r_state == S_IDLE);
    assign rd_word  = $signed(i_rdata);
    assign pos_slot = ADDR_W'(i_req.position - POS_W'(1));
    assign not_full = r_count < CNT_W'(CAPACITY);
    assign get_ok   = (i_req.position != '0) &&
                      (CMP_W'(i_req.position) <= CMP_W'(r_count));
    assign ins_ok   = (i_req.position != '0) &&
                      (CMP_W'(i_req.position) <= CMP_W'(r_count) + CMP_W'(1));
    assign ins_slot = (i_req.operation == OP_PUSH) ? '0 : pos_slot;
    assign at_end   = (CNT_W'(r_idx) == r_count - CNT_W'(1));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_slot       = r_slot;
        n_val        = r_val;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        fin          = 1'b0;
        fin_status   = ST_OK;
        o_ram.we     = 1'b0;
        o_ram.waddr  = r_idx;
        o_ram.wdata  = i_rdata;
        o_ram.raddr  = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.operation) inside
                        OP_SHOW: begin
                            if (r_count == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                o_ram.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_SHOW;
                            end
                        end
                        OP_GET: begin
                            if (get_ok) begin
                                o_ram.raddr = pos_slot;
                                n_idx       = pos_slot;
                                n_state     = S_GET;
                            end else begin
                                fin        = 1'b1;
                                fin_status = ST_FAIL;
                            end
                        end
                        OP_INSERT, OP_PUSH: begin
                            if (not_full && (ins_ok || i_req.operation == OP_PUSH)) begin
                                if (CNT_W'(ins_slot) == r_count) begin
                                    o_ram.we    = 1'b1;
                                    o_ram.waddr = ins_slot;
                                    o_ram.wdata = i_req.item_value;
                                    n_count     = r_count + CNT_W'(1);
                                    fin         = 1'b1;
                                end else begin
                                    o_ram.raddr = ADDR_W'(r_count - CNT_W'(1));
                                    n_idx       = ADDR_W'(r_count - CNT_W'(1));
                                    n_slot      = ins_slot;
                                    n_val       = i_req.item_value;
                                    n_state     = S_UP;
                                end
                            end else begin
                                fin        = 1'b1;
                                fin_status = ST_FAIL;
                            end
                        end
                        OP_DELETE: begin
                            if (get_ok) begin
                                if (CNT_W'(i_req.position) == r_count) begin
                                    n_count = r_count - CNT_W'(1);
                                    fin     = 1'b1;
                                end else begin
                                    o_ram.raddr = pos_slot + ADDR_W'(1);
                                    n_idx       = pos_slot + ADDR_W'(1);
                                    n_state     = S_DN;
                                end
                            end else begin
                                fin        = 1'b1;
                                fin_status = ST_FAIL;
                            end
                        end
                        default: begin
                            fin        = 1'b1;
                            fin_status = ST_FAIL;
                        end
                    endcase
                end
            end
            S_GET: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_value  = rd_word;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SHOW: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_value  = rd_word;
                    n_out_last   = at_end;
                    if (at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram.raddr = r_idx + ADDR_W'(1);
                        n_idx       = r_idx + ADDR_W'(1);
                    end
                end
            end
            S_UP: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx + ADDR_W'(1);
                if (r_idx == r_slot) begin
                    n_state = S_PUTV;
                end else begin
                    o_ram.raddr = r_idx - ADDR_W'(1);
                    n_idx       = r_idx - ADDR_W'(1);
                end
            end
            S_PUTV: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_slot;
                o_ram.wdata = r_val;
                n_count     = r_count + CNT_W'(1);
                fin         = 1'b1;
            end
            S_DN: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx - ADDR_W'(1);
                if (at_end) begin
                    n_count = r_count - CNT_W'(1);
                    fin     = 1'b1;
                end else begin
                    o_ram.raddr = r_idx + ADDR_W'(1);
                    n_idx       = r_idx + ADDR_W'(1);
                end
            end
            S_DONE: begin
                fin        = 1'b1;
                fin_status = r_status;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = fin_status;
                n_out_value  = '0;
                n_out_last   = 1'b1;
                n_state      = S_IDLE;
            end else begin
                n_status = fin_status;
                n_state  = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_slot       <= n_slot;
        r_val        <= n_val;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.last       = r_out_last;
endmodule

### design/positional_list_engine_core.sv
// Top level of the positional list engine: sequencer and entry memory.
`timescale 1ns / 1ps
// The engine keeps an ordered list of signed 32-bit values in a RAM with registered read
// data and takes one request at a time. Requests that fail, delete the final entry, or
// insert just after the final entry are decided in the cycle they are accepted. Insert
// at p (push front: p = 1) moves count-p+1 entries, one per cycle through the single RAM
// write port, then writes the new value in S_PUTV; delete at p moves count-p entries, one
// per cycle; show delivers one result per cycle while the output register is free. A
// completed result sits in an output register, so a new request is taken while it waits.
// Entries at or beyond the count are never used, so no clearing pass runs.
module positional_list_engine_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ple_req_if.sink   i_req,
    ple_rsp_if.source o_rsp
);
    import ple_pkg::*;

    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    ple_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_ram   (ram_req),
        .i_rdata (ram_rdata)
    );

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );
endmodule

### design/ple_chk.sv
// Port-level checker of the positional list engine and its bind to the top level.
`timescale 1ns / 1ps
module ple_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input ple_pkg::t_status           i_rsp_status,
    input logic [ple_pkg::DATA_W-1:0] i_rsp_value,
    input logic                       i_rsp_last
);
    import ple_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) &&
        $stable(i_rsp_value) && $stable(i_rsp_last))
        else $error("A stalled result changed before it was taken.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("A result appeared straight after reset.");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_last)
        else $error("A failed or empty result was not the final one of its request.");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_value == '0)
        else $error("A failed or empty result carried a non-zero value.");
endmodule

bind positional_list_engine_core ple_chk u_ple_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_value  (o_rsp.read_value),
    .i_rsp_last   (o_rsp.last)
);

### test/testbench.sv
// Self-checking testbench of the positional list engine with a scoreboard that mirrors the list.
`timescale 1ns / 1ps
module testbench;
    import ple_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REQUEST_TARGET = 260;

    typedef struct {
        t_status status;
        t_word   read_value;
        logic    last;
    } t_list_result;

    class list_tracker;
        t_word        stored [CAPACITY];
        int           fill_level = 0;
        t_list_result pending [$];
        int           errors = 0;
        int           requests = 0;
        int           results = 0;
        int           full_rejects = 0;
        int           peak_level = 0;

        function void add_expected(input t_status status, input t_word value, input logic last);
            t_list_result r;
            r.status = status;
            r.read_value = value;
            r.last = last;
            pending.push_back(r);
        endfunction

        function void place_entry(input int slot, input t_word value);
            for (int i = fill_level; i > slot; i--) stored[i] = stored[i-1];
            stored[slot] = value;
            fill_level++;
            if (fill_level > peak_level) peak_level = fill_level;
        endfunction

        function void note_request(input t_op op, input t_pos pos, input t_word value);
            int p;
            p = int'(pos);
            requests++;
            case (op)
                OP_SHOW: begin
                    if (fill_level == 0) begin
                        add_expected(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill_level; i++)
                            add_expected(ST_OK, stored[i], i == fill_level - 1);
                    end
                end
                OP_GET: begin
                    if (p >= 1 && p <= fill_level) add_expected(ST_OK, stored[p-1], 1'b1);
                    else add_expected(ST_FAIL, '0, 1'b1);
                end
                OP_INSERT: begin
                    if (p >= 1 && p <= fill_level + 1 && fill_level < CAPACITY) begin
                        place_entry(p - 1, value);
                        add_expected(ST_OK, '0, 1'b1);
                    end else begin
                        if (fill_level == CAPACITY) full_rejects++;
                        add_expected(ST_FAIL, '0, 1'b1);
                    end
                end
                OP_DELETE: begin
                    if (p >= 1 && p <= fill_level) begin
                        for (int i = p - 1; i + 1 < fill_level; i++) stored[i] = stored[i+1];
                        fill_level--;
                        add_expected(ST_OK, '0, 1'b1);
                    end else begin
                        add_expected(ST_FAIL, '0, 1'b1);
                    end
                end
                OP_PUSH: begin
                    if (fill_level < CAPACITY) begin
                        place_entry(0, value);
                        add_expected(ST_OK, '0, 1'b1);
                    end else begin
                        full_rejects++;
                        add_expected(ST_FAIL, '0, 1'b1);
                    end
                end
                default: add_expected(ST_FAIL, '0, 1'b1);
            endcase
        endfunction

        function void check_response(input t_status status, input t_word value, input logic last);
            t_list_result r;
            results++;
            if (pending.size() == 0) begin
                $error("Result arrived with none expected: status %0d, read_value %0d",
                       status, value);
                errors++;
            end else begin
                r = pending.pop_front();
                if (status !== r.status) begin
                    $error("status mismatch: expected %0d, got %0d", r.status, status);
                    errors++;
                end
                if (value !== r.read_value) begin
                    $error("read_value mismatch: expected %0d, got %0d", r.read_value, value);
                    errors++;
                end
                if (last !== r.last) begin
                    $error("last mismatch: expected %0b, got %0b", r.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic gaps_on = 1'b1;
    int   cycles = 0;

    ple_req_if req_bus ();
    ple_rsp_if rsp_bus ();

    list_tracker tracker = new;

    positional_list_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial rsp_bus.ready = 1'b0;

    always @(negedge i_clk) begin
        if (gaps_on && $urandom_range(0, 99) < 25) rsp_bus.ready <= 1'b0;
        else rsp_bus.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            tracker.check_response(rsp_bus.status, rsp_bus.read_value, rsp_bus.last);
    end

    function automatic t_pos pick_position(input int top);
        if (top >= 1 && $urandom_range(0, 99) < 85) return t_pos'($urandom_range(1, top));
        return t_pos'($urandom_range(0, 63));
    endfunction

    function automatic t_word pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return t_word'(32'h7FFF_FFFF);
        if (r == 1) return t_word'(32'h8000_0000);
        return t_word'($urandom());
    endfunction

    task automatic send_request(input t_op op, input t_pos pos, input t_word value);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 25) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.operation <= op;
        req_bus.position <= pos;
        req_bus.item_value <= value;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        tracker.note_request(op, pos, value);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic mixed_requests(input int n);
        int   r;
        t_op  op;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 3) op = t_op'(OP_PUSH + $urandom_range(1, 3));
            else if (r < 10) op = OP_SHOW;
            else if (r < 30) op = OP_GET;
            else if (r < 55) op = OP_INSERT;
            else if (r < 75 || tracker.fill_level > 24) op = OP_DELETE;
            else op = OP_PUSH;
            if (op == OP_INSERT) send_request(op, pick_position(tracker.fill_level + 1),
                                              pick_value());
            else send_request(op, pick_position(tracker.fill_level), pick_value());
        end
    endtask

    task automatic fill_list();
        while (tracker.fill_level < CAPACITY) begin
            if ($urandom_range(0, 1)) begin
                send_request(OP_PUSH, t_pos'($urandom_range(0, 63)), pick_value());
            end else begin
                send_request(OP_INSERT, t_pos'($urandom_range(1, tracker.fill_level + 1)),
                             pick_value());
            end
        end
        send_request(OP_INSERT, t_pos'($urandom_range(1, CAPACITY)), pick_value());
        send_request(OP_PUSH, t_pos'($urandom_range(0, 63)), pick_value());
        send_request(OP_SHOW, '0, pick_value());
        send_request(OP_GET, t_pos'(CAPACITY), pick_value());
        send_request(OP_GET, t_pos'(CAPACITY + 1), pick_value());
    endtask

    task automatic empty_list();
        while (tracker.fill_level > 0)
            send_request(OP_DELETE, t_pos'($urandom_range(1, tracker.fill_level)), pick_value());
        send_request(OP_SHOW, t_pos'($urandom_range(0, 63)), pick_value());
        send_request(OP_GET, t_pos'($urandom_range(0, 63)), pick_value());
        send_request(OP_DELETE, t_pos'($urandom_range(0, 63)), pick_value());
    endtask

    initial begin
        int phase;
        phase = 0;
        req_bus.valid = 1'b0;
        req_bus.operation = OP_SHOW;
        req_bus.position = '0;
        req_bus.item_value = '0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_SHOW, '0, '0);
        send_request(OP_GET, t_pos'(1), '0);
        send_request(OP_DELETE, t_pos'(1), '0);
        send_request(OP_GET, '0, '0);
        send_request(OP_INSERT, '0, t_word'(5));
        send_request(OP_INSERT, t_pos'(2), t_word'(6));
        send_request(OP_INSERT, t_pos'(1), t_word'(32'h7FFF_FFFF));
        send_request(OP_PUSH, '1, t_word'(32'h8000_0000));
        send_request(OP_INSERT, t_pos'(3), t_word'(-1));
        send_request(OP_INSERT, t_pos'(2), '0);
        send_request(OP_SHOW, '0, '1);
        send_request(OP_GET, t_pos'(4), '0);
        send_request(OP_GET, t_pos'(1), '1);
        send_request(OP_GET, t_pos'(5), '0);
        send_request(OP_GET, '1, '0);
        send_request(OP_INSERT, '1, t_word'(7));
        send_request(OP_DELETE, t_pos'(4), '0);
        send_request(OP_DELETE, t_pos'(1), '0);
        send_request(OP_DELETE, '1, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(t_op'(OP_PUSH + 1), t_pos'(1), '0);
        send_request(t_op'(OP_PUSH + 2), t_pos'(1), '0);
        send_request(t_op'(OP_PUSH + 3), t_pos'(1), '0);
        send_request(OP_SHOW, '0, '0);

        while (tracker.requests < REQUEST_TARGET) begin
            case (phase % 4)
                0: mixed_requests(40);
                1: begin
                    fill_list();
                    wait_for_results();
                end
                2: begin
                    gaps_on = (phase != 2);
                    mixed_requests(40);
                    gaps_on = 1'b1;
                end
                default: empty_list();
            endcase
            phase++;
        end

        wait_for_results();
        repeat (64) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results; the list peaked at %0d entries.",
                 tracker.requests, tracker.results, tracker.peak_level);
        $display("Inserts into a full list were refused %0d times; %0d results were missing.",
                 tracker.full_rejects, tracker.pending.size());
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
